FILE: rtl/lennard_jones_pair_energy_macros.svh
// assertion macros for the lennard-jones pair energy block
`ifndef LENNARD_JONES_PAIR_ENERGY_MACROS_SVH
`define LENNARD_JONES_PAIR_ENERGY_MACROS_SVH
// same-cycle implication, disabled in reset
`define LJE_ASSERT_IMPL(name, cond, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error(msg);
// next-cycle implication, disabled in reset
`define LJE_ASSERT_NEXT(name, cond, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error(msg);
`endif

FILE: rtl/lje_pkg.sv
// shared types, constants and state encodings of the pair energy block
`default_nettype none
package lje_pkg;
  localparam int MAX_ATOMS_DEF = 64;
  localparam int NUM_TYPES_DEF = 16;
  localparam int TYPE_W        = 4;
  localparam int POS_W         = 32;
  localparam int LEN_W         = 32;
  localparam int ENERGY_W      = 64;
  localparam int USED_W        = 7;
  localparam int IN_DATA_W     = 168;
  localparam int OUT_DATA_W    = 72;
  localparam int DIV_STEPS      = 96;
  localparam int DIV_OVER_STEPS = 32;

  localparam logic [LEN_W-1:0]    LEN_ONE    = 32'h0001_0000;
  localparam logic [ENERGY_W-1:0] ENERGY_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [ENERGY_W-1:0] ENERGY_MIN = 64'h8000_0000_0000_0000;
  localparam logic [ENERGY_W-1:0] TERM_LIMIT = 64'h2000_0000_0000_0000;

  // square steps of the term unit
  localparam logic [2:0] SQ_X   = 3'd0;
  localparam logic [2:0] SQ_Y   = 3'd1;
  localparam logic [2:0] SQ_Z   = 3'd2;
  localparam logic [2:0] SQ_REP = 3'd3;
  localparam logic [2:0] SQ_ATT = 3'd4;

  // fixed-point product chain of the term unit
  localparam logic [2:0] MQ_U2 = 3'd0;
  localparam logic [2:0] MQ_U4 = 3'd1;
  localparam logic [2:0] MQ_U6 = 3'd2;
  localparam logic [2:0] MQ_V2 = 3'd3;
  localparam logic [2:0] MQ_V6 = 3'd4;
  localparam logic [2:0] MQ_LAST_PART = 3'd3;

  typedef enum logic [1:0] {
    KIND_PARAM   = 2'd0,
    KIND_ATOM    = 2'd1,
    KIND_COMPUTE = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef struct packed {
    logic [TYPE_W-1:0] atype;
    logic [POS_W-1:0]  z;
    logic [POS_W-1:0]  y;
    logic [POS_W-1:0]  x;
  } atom_t;

  typedef struct packed {
    logic             start;
    atom_t            a;
    atom_t            b;
    logic [LEN_W-1:0] rep;
    logic [LEN_W-1:0] att;
  } term_req_t;

  typedef struct packed {
    logic                       busy;
    logic                       done;
    logic                       sat;
    logic signed [ENERGY_W-1:0] term;
  } term_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD_I, ST_LAT_I, ST_RD_J, ST_LAT_J, ST_LUT, ST_WAIT, ST_OUT
  } top_state_t;

  typedef enum logic [3:0] {
    TS_IDLE, TS_SQ_MUL, TS_SQ_ACC, TS_DIV, TS_MQ_MUL, TS_MQ_ACC, TS_MQ_FIN,
    TS_DIFF, TS_CLAMP
  } term_state_t;
endpackage
`default_nettype wire

FILE: rtl/lje_term.sv
// pair term unit: squared distance, bit-serial ratios, power chain, clamp
`default_nettype none
module lje_term (
  input  logic               clk,
  input  logic               rst_n,
  input  lje_pkg::term_req_t req,
  output lje_pkg::term_rsp_t rsp
);
  lje_pkg::term_state_t state_r, state_nxt;
  logic [2:0]   step_r, step_nxt;
  logic [2:0]   op_r, op_nxt;
  logic [6:0]   cnt_r, cnt_nxt;
  logic         done_r, done_nxt;
  logic [32:0]  ax_r, ay_r, az_r;
  logic [31:0]  rep_r, att_r;
  logic [32:0]  mul_a, mul_b;
  logic [65:0]  prod_r;
  logic [127:0] acc_r;
  logic [127:0] mq_part;
  logic [65:0]  d2_r;
  logic         d2_zero;
  logic [95:0]  num_r [2];
  logic [65:0]  rem_r [2];
  logic [63:0]  quo_r [2];
  logic [1:0]   over_r;
  logic [66:0]  div_sh [2];
  logic [1:0]   div_ge;
  logic [65:0]  div_rem [2];
  logic [63:0]  res_r [5];
  logic [63:0]  u_val, v_val, opa, opb;
  logic [63:0]  diff_r;
  logic         ge_r;
  logic         sat_r;
  logic signed [63:0] term_r;

  function automatic logic [32:0] abs_diff(input logic [31:0] p, input logic [31:0] q);
    logic signed [32:0] d;
    d = $signed({p[31], p}) - $signed({q[31], q});
    abs_diff = d[32] ? $unsigned(-d) : $unsigned(d);
  endfunction

  assign u_val   = over_r[0] ? '1 : quo_r[0];
  assign v_val   = over_r[1] ? '1 : quo_r[1];
  assign d2_zero = (acc_r[65:0] == '0);

  always_comb begin
    opa = '0;
    opb = '0;
    case (op_r)
      lje_pkg::MQ_U2: begin opa = u_val; opb = u_val; end
      lje_pkg::MQ_U4: begin opa = res_r[lje_pkg::MQ_U2]; opb = res_r[lje_pkg::MQ_U2]; end
      lje_pkg::MQ_U6: begin opa = res_r[lje_pkg::MQ_U4]; opb = res_r[lje_pkg::MQ_U2]; end
      lje_pkg::MQ_V2: begin opa = v_val; opb = v_val; end
      lje_pkg::MQ_V6: begin opa = res_r[lje_pkg::MQ_V2]; opb = v_val; end
      default: ;
    endcase
    mul_a = '0;
    mul_b = '0;
    if (state_r == lje_pkg::TS_SQ_MUL) begin
      case (step_r)
        lje_pkg::SQ_X:   begin mul_a = ax_r; mul_b = ax_r; end
        lje_pkg::SQ_Y:   begin mul_a = ay_r; mul_b = ay_r; end
        lje_pkg::SQ_Z:   begin mul_a = az_r; mul_b = az_r; end
        lje_pkg::SQ_REP: begin mul_a = {1'b0, rep_r}; mul_b = {1'b0, rep_r}; end
        lje_pkg::SQ_ATT: begin mul_a = {1'b0, att_r}; mul_b = {1'b0, att_r}; end
        default: ;
      endcase
    end else begin
      // 32x32 partial products, low halves first
      mul_a = {1'b0, step_r[1] ? opa[63:32] : opa[31:0]};
      mul_b = {1'b0, step_r[0] ? opb[63:32] : opb[31:0]};
    end
  end

  always_comb begin
    case (step_r)
      3'd0:       mq_part = {62'b0, prod_r};
      3'd1, 3'd2: mq_part = {62'b0, prod_r} << 32;
      3'd3:       mq_part = {62'b0, prod_r} << 64;
      default:    mq_part = '0;
    endcase
  end

  // one restoring division step per lane
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      div_sh[k]  = {rem_r[k], num_r[k][95]};
      div_ge[k]  = (div_sh[k] >= {1'b0, d2_r});
      div_rem[k] = div_ge[k] ? 66'(div_sh[k] - {1'b0, d2_r}) : div_sh[k][65:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    op_nxt    = op_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    case (state_r)
      lje_pkg::TS_IDLE: begin
        if (req.start) begin
          state_nxt = lje_pkg::TS_SQ_MUL;
          step_nxt  = lje_pkg::SQ_X;
        end
      end
      lje_pkg::TS_SQ_MUL: state_nxt = lje_pkg::TS_SQ_ACC;
      lje_pkg::TS_SQ_ACC: begin
        if (step_r == lje_pkg::SQ_ATT) begin
          if (d2_zero) begin
            state_nxt = lje_pkg::TS_IDLE;
            done_nxt  = 1'b1;
          end else begin
            state_nxt = lje_pkg::TS_DIV;
            cnt_nxt   = '0;
          end
        end else begin
          state_nxt = lje_pkg::TS_SQ_MUL;
          step_nxt  = step_r + 3'd1;
        end
      end
      lje_pkg::TS_DIV: begin
        if (cnt_r == 7'(lje_pkg::DIV_STEPS - 1)) begin
          state_nxt = lje_pkg::TS_MQ_MUL;
          step_nxt  = '0;
          op_nxt    = lje_pkg::MQ_U2;
        end else begin
          cnt_nxt = cnt_r + 7'd1;
        end
      end
      lje_pkg::TS_MQ_MUL: state_nxt = lje_pkg::TS_MQ_ACC;
      lje_pkg::TS_MQ_ACC: begin
        if (step_r == lje_pkg::MQ_LAST_PART) begin
          state_nxt = lje_pkg::TS_MQ_FIN;
        end else begin
          state_nxt = lje_pkg::TS_MQ_MUL;
          step_nxt  = step_r + 3'd1;
        end
      end
      lje_pkg::TS_MQ_FIN: begin
        if (op_r == lje_pkg::MQ_V6) begin
          state_nxt = lje_pkg::TS_DIFF;
        end else begin
          state_nxt = lje_pkg::TS_MQ_MUL;
          step_nxt  = '0;
          op_nxt    = op_r + 3'd1;
        end
      end
      lje_pkg::TS_DIFF: state_nxt = lje_pkg::TS_CLAMP;
      lje_pkg::TS_CLAMP: begin
        state_nxt = lje_pkg::TS_IDLE;
        done_nxt  = 1'b1;
      end
      default: state_nxt = lje_pkg::TS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lje_pkg::TS_IDLE;
      step_r  <= '0;
      op_r    <= '0;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      op_r    <= op_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      lje_pkg::TS_IDLE: begin
        if (req.start) begin
          ax_r  <= abs_diff(req.a.x, req.b.x);
          ay_r  <= abs_diff(req.a.y, req.b.y);
          az_r  <= abs_diff(req.a.z, req.b.z);
          rep_r <= req.rep;
          att_r <= req.att;
          sat_r <= 1'b0;
        end
      end
      lje_pkg::TS_SQ_MUL, lje_pkg::TS_MQ_MUL: prod_r <= mul_a * mul_b;
      lje_pkg::TS_SQ_ACC: begin
        case (step_r)
          lje_pkg::SQ_X:               acc_r <= {62'b0, prod_r};
          lje_pkg::SQ_Y, lje_pkg::SQ_Z: acc_r <= acc_r + {62'b0, prod_r};
          lje_pkg::SQ_REP:             num_r[0] <= {prod_r[63:0], 32'b0};
          lje_pkg::SQ_ATT: begin
            num_r[1] <= {prod_r[63:0], 32'b0};
            d2_r     <= acc_r[65:0];
            rem_r[0] <= '0;
            rem_r[1] <= '0;
            over_r   <= '0;
            if (d2_zero) term_r <= '0;
          end
          default: ;
        endcase
      end
      lje_pkg::TS_DIV: begin
        for (int k = 0; k < 2; k++) begin
          rem_r[k] <= div_rem[k];
          num_r[k] <= num_r[k] << 1;
          quo_r[k] <= {quo_r[k][62:0], div_ge[k]};
          // quotient bits above the low 64 mean the ratio overflows
          if (div_ge[k] && (cnt_r < 7'(lje_pkg::DIV_OVER_STEPS))) over_r[k] <= 1'b1;
        end
        if (cnt_r == 7'(lje_pkg::DIV_STEPS - 1)) sat_r <= sat_r | (|over_r);
      end
      lje_pkg::TS_MQ_ACC: begin
        acc_r <= ((step_r == 3'd0) ? 128'b0 : acc_r) + mq_part;
      end
      lje_pkg::TS_MQ_FIN: begin
        if (|acc_r[127:96]) begin
          res_r[op_r] <= '1;
          sat_r       <= 1'b1;
        end else begin
          res_r[op_r] <= acc_r[95:32];
        end
      end
      lje_pkg::TS_DIFF: begin
        ge_r <= (res_r[lje_pkg::MQ_U6] >= res_r[lje_pkg::MQ_V6]);
        diff_r <= (res_r[lje_pkg::MQ_U6] >= res_r[lje_pkg::MQ_V6]) ?
                  res_r[lje_pkg::MQ_U6] - res_r[lje_pkg::MQ_V6] :
                  res_r[lje_pkg::MQ_V6] - res_r[lje_pkg::MQ_U6];
      end
      lje_pkg::TS_CLAMP: begin
        if (ge_r) begin
          if (|diff_r[63:61]) begin
            term_r <= lje_pkg::ENERGY_MAX;
            sat_r  <= 1'b1;
          end else begin
            term_r <= {diff_r[61:0], 2'b00};
          end
        end else if (|diff_r[63:61]) begin
          // exactly the negative limit is representable
          term_r <= lje_pkg::ENERGY_MIN;
          if (diff_r != lje_pkg::TERM_LIMIT) sat_r <= 1'b1;
        end else begin
          term_r <= 64'b0 - {diff_r[61:0], 2'b00};
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    rsp.busy = (state_r != lje_pkg::TS_IDLE);
    rsp.done = done_r;
    rsp.sat  = sat_r;
    rsp.term = term_r;
  end
endmodule
`default_nettype wire

FILE: rtl/lennard_jones_pair_energy.sv
// top level of the lennard-jones pair energy block: stores, pair walk, sum, output
`default_nettype none
`include "lennard_jones_pair_energy_macros.svh"
// Parameter and atom loads are accepted back to back. A compute beat walks every unordered
// pair of stored atoms, one pair at a time, and holds the input off for the whole walk: each
// pair takes atom and table memory reads, five squares on the shared 33x33 multiplier, a
// 96-step bit-serial divider for the two length ratios, and five 64-bit fixed-point products
// built from four partial products each, while a pair of coincident atoms skips the divider
// and the products; n atoms take n*(n-1)/2 pairs. A compute with fewer than two atoms goes
// straight to the output state. The result waits in an output register while new loads are
// taken. Atom and parameter stores are simple dual-port memories (one write port, one
// registered read port); the parameter table's valid bits clear at reset.
module lennard_jones_pair_energy #(
  parameter int MAX_ATOMS = lje_pkg::MAX_ATOMS_DEF,
  parameter int NUM_TYPES = lje_pkg::NUM_TYPES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // pos_x, pos_y, pos_z, type_first, type_second, repulsive_len, attractive_len
  input  logic [lje_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [1:0]                     in_tuser,   // kind
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [lje_pkg::OUT_DATA_W-1:0] out_tdata,  // total_energy, atoms_used, zero pad
  output logic [1:0]                     out_tuser   // saturated, atoms_dropped
);
  localparam int IDX_W      = $clog2(MAX_ATOMS);
  localparam int CNT_W      = $clog2(MAX_ATOMS + 1);
  localparam int TYPE_SPAN  = 1 << lje_pkg::TYPE_W;
  localparam int TYPES_USED = (NUM_TYPES < TYPE_SPAN) ? NUM_TYPES : TYPE_SPAN;
  localparam int KEYS       = TYPES_USED * TYPES_USED;
  localparam int KEY_W      = $clog2(KEYS);

  lje_pkg::top_state_t state_r, state_nxt;
  lje_pkg::kind_t      in_kind;
  lje_pkg::atom_t      in_atom;
  lje_pkg::atom_t      atom_mem [MAX_ATOMS];
  lje_pkg::atom_t      atom_q_r, ai_r, aj_r;
  lje_pkg::term_req_t  term_req;
  lje_pkg::term_rsp_t  term_rsp;

  logic [lje_pkg::TYPE_W-1:0] in_t1, in_t2;
  logic [lje_pkg::LEN_W-1:0]  in_rep, in_att;
  logic [63:0]                pair_mem [KEYS];
  logic [63:0]                pair_q_r;
  logic [KEYS-1:0]            pvalid_r;
  logic                       use_tab_r;
  logic [KEY_W-1:0]           wr_key, key_ab, key_ba, tab_addr;
  logic                       types_ok, v_ab, v_ba;
  logic [CNT_W-1:0]           cnt_r;
  logic [CNT_W+lje_pkg::USED_W-1:0] cnt_ext;
  logic                       drop_r;
  logic [IDX_W-1:0]           i_r, j_r, rd_addr;
  logic                       in_acc, atom_full, last_j, last_i, out_free;
  logic                       atom_wr, pair_wr, drop_set, walk_start, term_start, out_load;
  logic signed [lje_pkg::ENERGY_W-1:0] sum_r;
  logic signed [lje_pkg::ENERGY_W:0]   sum_ext;
  logic                       sum_ovf, sumsat_r;
  logic                       out_valid_r;
  logic [lje_pkg::OUT_DATA_W-1:0] out_data_r;
  logic [1:0]                 out_user_r;

  function automatic logic type_ok(input logic [lje_pkg::TYPE_W-1:0] t);
    type_ok = (int'(t) < NUM_TYPES);
  endfunction

  function automatic logic [KEY_W-1:0] pair_key(input logic [lje_pkg::TYPE_W-1:0] ta,
                                                input logic [lje_pkg::TYPE_W-1:0] tb);
    pair_key = KEY_W'(int'(ta) * TYPES_USED + int'(tb));
  endfunction

  assign in_kind     = lje_pkg::kind_t'(in_tuser);
  assign in_atom.x   = in_tdata[31:0];
  assign in_atom.y   = in_tdata[63:32];
  assign in_atom.z   = in_tdata[95:64];
  assign in_t1       = in_tdata[99:96];
  assign in_t2       = in_tdata[103:100];
  assign in_rep      = in_tdata[135:104];
  assign in_att      = in_tdata[167:136];
  assign in_atom.atype = in_t1;

  assign in_tready = (state_r == lje_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign atom_full = (cnt_r == CNT_W'(MAX_ATOMS));
  assign last_j    = ((CNT_W'(j_r) + CNT_W'(1)) == cnt_r);
  assign last_i    = ((CNT_W'(i_r) + CNT_W'(2)) == cnt_r);
  assign out_free  = !out_valid_r || out_tready;
  assign wr_key    = pair_key(in_t1, in_t2);
  assign rd_addr   = (state_r == lje_pkg::ST_RD_I) ? i_r : j_r;

  // parameter lookup: (i,j) first, then (j,i), else unit lengths
  assign types_ok = type_ok(ai_r.atype) && type_ok(atom_q_r.atype);
  assign key_ab   = pair_key(ai_r.atype, atom_q_r.atype);
  assign key_ba   = pair_key(atom_q_r.atype, ai_r.atype);
  assign v_ab     = types_ok && pvalid_r[key_ab];
  assign v_ba     = types_ok && pvalid_r[key_ba];
  assign tab_addr = v_ab ? key_ab : key_ba;

  assign sum_ext = {sum_r[lje_pkg::ENERGY_W-1], sum_r} +
                   {term_rsp.term[lje_pkg::ENERGY_W-1], term_rsp.term};
  assign sum_ovf = (sum_ext[lje_pkg::ENERGY_W] != sum_ext[lje_pkg::ENERGY_W-1]);
  assign cnt_ext = {{lje_pkg::USED_W{1'b0}}, cnt_r};

  always_comb begin
    term_req.start = term_start;
    term_req.a     = ai_r;
    term_req.b     = aj_r;
    term_req.rep   = use_tab_r ? pair_q_r[31:0] : lje_pkg::LEN_ONE;
    term_req.att   = use_tab_r ? pair_q_r[63:32] : lje_pkg::LEN_ONE;
  end

  lje_term u_term (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (term_req),
    .rsp   (term_rsp)
  );

  always_comb begin
    state_nxt  = state_r;
    atom_wr    = 1'b0;
    pair_wr    = 1'b0;
    drop_set   = 1'b0;
    walk_start = 1'b0;
    term_start = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      lje_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_kind)
            lje_pkg::KIND_PARAM: pair_wr = type_ok(in_t1) && type_ok(in_t2);
            lje_pkg::KIND_ATOM: begin
              if (atom_full) drop_set = 1'b1;
              else atom_wr = 1'b1;
            end
            lje_pkg::KIND_COMPUTE: begin
              walk_start = 1'b1;
              state_nxt  = (cnt_r < CNT_W'(2)) ? lje_pkg::ST_OUT : lje_pkg::ST_RD_I;
            end
            lje_pkg::KIND_NONE: ;
            default: ;
          endcase
        end
      end
      lje_pkg::ST_RD_I:  state_nxt = lje_pkg::ST_LAT_I;
      lje_pkg::ST_LAT_I: state_nxt = lje_pkg::ST_LAT_J;
      lje_pkg::ST_RD_J:  state_nxt = lje_pkg::ST_LAT_J;
      lje_pkg::ST_LAT_J: state_nxt = lje_pkg::ST_LUT;
      lje_pkg::ST_LUT: begin
        term_start = 1'b1;
        state_nxt  = lje_pkg::ST_WAIT;
      end
      lje_pkg::ST_WAIT: begin
        if (term_rsp.done) begin
          if (!last_j) state_nxt = lje_pkg::ST_RD_J;
          else if (last_i) state_nxt = lje_pkg::ST_OUT;
          else state_nxt = lje_pkg::ST_RD_I;
        end
      end
      lje_pkg::ST_OUT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = lje_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lje_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lje_pkg::ST_IDLE;
      cnt_r       <= '0;
      drop_r      <= 1'b0;
      pvalid_r    <= '0;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
    end else begin
      state_r <= state_nxt;
      if (atom_wr) cnt_r <= cnt_r + CNT_W'(1);
      if (drop_set) drop_r <= 1'b1;
      if (pair_wr) pvalid_r[wr_key] <= 1'b1;
      if (out_load) begin
        cnt_r  <= '0;
        drop_r <= 1'b0;
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      if (walk_start) begin
        i_r <= '0;
        j_r <= IDX_W'(1);
      end else if (state_r == lje_pkg::ST_WAIT && term_rsp.done) begin
        if (last_j) begin
          i_r <= i_r + IDX_W'(1);
          j_r <= i_r + IDX_W'(2);
        end else begin
          j_r <= j_r + IDX_W'(1);
        end
      end
    end
  end

  // atom store
  always_ff @(posedge clk) begin
    if (atom_wr) atom_mem[IDX_W'(cnt_r)] <= in_atom;
    atom_q_r <= atom_mem[rd_addr];
  end

  // pair parameter table, {attractive, repulsive}
  always_ff @(posedge clk) begin
    if (pair_wr) pair_mem[wr_key] <= {in_att, in_rep};
    pair_q_r <= pair_mem[tab_addr];
  end

  always_ff @(posedge clk) begin
    if (state_r == lje_pkg::ST_LAT_I) ai_r <= atom_q_r;
    if (state_r == lje_pkg::ST_LAT_J) begin
      aj_r      <= atom_q_r;
      use_tab_r <= v_ab || v_ba;
    end
    if (walk_start) begin
      sum_r    <= '0;
      sumsat_r <= 1'b0;
    end else if (state_r == lje_pkg::ST_WAIT && term_rsp.done) begin
      if (sum_ovf) begin
        sum_r <= sum_ext[lje_pkg::ENERGY_W] ? lje_pkg::ENERGY_MIN : lje_pkg::ENERGY_MAX;
      end else begin
        sum_r <= sum_ext[lje_pkg::ENERGY_W-1:0];
      end
      sumsat_r <= sumsat_r | sum_ovf | term_rsp.sat;
    end
    if (out_load) begin
      out_data_r <= {1'b0, cnt_ext[lje_pkg::USED_W-1:0], sum_r};
      out_user_r <= {drop_r, sumsat_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `LJE_ASSERT_IMPL(a_done_in_wait, term_rsp.done, state_r == lje_pkg::ST_WAIT, "term result outside pair wait")
  `LJE_ASSERT_IMPL(a_start_idle, term_req.start, !term_rsp.busy, "term unit started while busy")
  `LJE_ASSERT_NEXT(a_count_clear, out_load, cnt_r == '0, "atom count not cleared after result")
endmodule
`default_nettype wire

FILE: tb/lje_energy_checker.sv
// checker of the pair energy block: watches both channels, predicts the energy and compares
`timescale 1ns / 100ps
module lje_energy_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [lje_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [1:0]                     in_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [lje_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic [1:0]                     out_tuser,
  output int                             mismatches,
  output int                             pending
);
  localparam int ATOM_CAP  = lje_pkg::MAX_ATOMS_DEF;
  localparam int TYPE_CNT  = lje_pkg::NUM_TYPES_DEF;
  localparam logic [63:0] QUARTER_MAX = 64'h1fff_ffff_ffff_ffff;

  typedef struct packed {
    logic [63:0] energy;
    logic [6:0]  used;
    logic        clamped;
    logic        dropped;
  } energy_result_t;

  logic [31:0] px [ATOM_CAP];
  logic [31:0] py [ATOM_CAP];
  logic [31:0] pz [ATOM_CAP];
  logic [3:0]  ptype [ATOM_CAP];
  int          stored;
  logic        drop_seen;
  logic [31:0] rep_tab [TYPE_CNT*TYPE_CNT];
  logic [31:0] att_tab [TYPE_CNT*TYPE_CNT];
  logic        tab_ok [TYPE_CNT*TYPE_CNT];
  logic        clamp_seen;
  energy_result_t energy_q [$];

  assign pending = energy_q.size();

  function automatic logic [63:0] len_ratio_sq(logic [31:0] len, logic [127:0] d2);
    logic [127:0] q;
    q = (({96'd0, len} * {96'd0, len}) << 32) / d2;
    if (q[127:64] != 0) begin
      clamp_seen = 1'b1;
      return '1;
    end
    return q[63:0];
  endfunction

  function automatic logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    if (p[127:96] != 0) begin
      clamp_seen = 1'b1;
      return '1;
    end
    return p[95:32];
  endfunction

  function automatic logic [63:0] axis_gap(logic [31:0] p, logic [31:0] q);
    logic signed [33:0] d;
    d = $signed({{2{p[31]}}, p}) - $signed({{2{q[31]}}, q});
    if (d < 0) d = -d;
    return {30'd0, d[33:0]};
  endfunction

  function automatic logic [63:0] lj_term(int i, int j);
    logic [63:0] gx, gy, gz, u, v, u2, uu, vv, diff;
    logic [127:0] d2;
    logic [31:0] rep, att;
    int ti, tj;
    gx = axis_gap(px[i], px[j]);
    gy = axis_gap(py[i], py[j]);
    gz = axis_gap(pz[i], pz[j]);
    d2 = {64'd0, gx} * gx + {64'd0, gy} * gy + {64'd0, gz} * gz;
    if (d2 == 0) return 64'd0;
    ti = ptype[i];
    tj = ptype[j];
    rep = lje_pkg::LEN_ONE;
    att = lje_pkg::LEN_ONE;
    if (tab_ok[ti*TYPE_CNT+tj]) begin
      rep = rep_tab[ti*TYPE_CNT+tj];
      att = att_tab[ti*TYPE_CNT+tj];
    end else if (tab_ok[tj*TYPE_CNT+ti]) begin
      rep = rep_tab[tj*TYPE_CNT+ti];
      att = att_tab[tj*TYPE_CNT+ti];
    end
    u = len_ratio_sq(rep, d2);
    v = len_ratio_sq(att, d2);
    u2 = fx_mul(u, u);
    uu = fx_mul(fx_mul(u2, u2), u2);
    vv = fx_mul(fx_mul(v, v), v);
    if (uu >= vv) begin
      diff = uu - vv;
      if (diff > QUARTER_MAX) begin
        clamp_seen = 1'b1;
        return lje_pkg::ENERGY_MAX;
      end
      return diff << 2;
    end
    diff = vv - uu;
    if (diff >= lje_pkg::TERM_LIMIT) begin
      if (diff > lje_pkg::TERM_LIMIT) clamp_seen = 1'b1;
      return lje_pkg::ENERGY_MIN;
    end
    return -(diff << 2);
  endfunction

  function automatic energy_result_t total_energy();
    energy_result_t r;
    logic [64:0] s;
    logic [63:0] acc, t;
    clamp_seen = 1'b0;
    acc = '0;
    for (int i = 0; i < stored; i++) begin
      for (int j = i + 1; j < stored; j++) begin
        t = lj_term(i, j);
        s = {acc[63], acc} + {t[63], t};
        if (s[64] != s[63]) begin
          clamp_seen = 1'b1;
          acc = s[64] ? lje_pkg::ENERGY_MIN : lje_pkg::ENERGY_MAX;
        end else begin
          acc = s[63:0];
        end
      end
    end
    r.energy = acc;
    r.used = stored[6:0];
    r.clamped = clamp_seen;
    r.dropped = drop_seen;
    return r;
  endfunction

  always @(posedge clk) begin
    energy_result_t got, want;
    logic [3:0] t1, t2;
    if (!rst_n) begin
      stored <= 0;
      drop_seen <= 1'b0;
      mismatches <= 0;
      energy_q.delete();
      for (int k = 0; k < TYPE_CNT*TYPE_CNT; k++) tab_ok[k] = 1'b0;
    end else begin
      // output first so a result never meets its own compute beat
      if (out_tvalid && out_tready) begin
        got.energy = out_tdata[63:0];
        got.used = out_tdata[70:64];
        got.clamped = out_tuser[0];
        got.dropped = out_tuser[1];
        if (energy_q.size() == 0) begin
          $display("%0t: result beat with none expected: energy %h used %0d sat %b drop %b",
                   $time, got.energy, got.used, got.clamped, got.dropped);
          mismatches <= mismatches + 1;
        end else begin
          want = energy_q.pop_front();
          if (got != want) begin
            $display("%0t: mismatch expected energy %h used %0d sat %b drop %b",
                     $time, want.energy, want.used, want.clamped, want.dropped);
            $display("%0t:          actual   energy %h used %0d sat %b drop %b",
                     $time, got.energy, got.used, got.clamped, got.dropped);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        t1 = in_tdata[99:96];
        t2 = in_tdata[103:100];
        case (lje_pkg::kind_t'(in_tuser))
          lje_pkg::KIND_PARAM: begin
            rep_tab[t1*TYPE_CNT+t2] = in_tdata[135:104];
            att_tab[t1*TYPE_CNT+t2] = in_tdata[167:136];
            tab_ok[t1*TYPE_CNT+t2] = 1'b1;
          end
          lje_pkg::KIND_ATOM: begin
            if (stored >= ATOM_CAP) begin
              drop_seen <= 1'b1;
            end else begin
              px[stored] = in_tdata[31:0];
              py[stored] = in_tdata[63:32];
              pz[stored] = in_tdata[95:64];
              ptype[stored] = t1;
              stored <= stored + 1;
            end
          end
          lje_pkg::KIND_COMPUTE: begin
            energy_q.push_back(total_energy());
            stored <= 0;
            drop_seen <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end
endmodule

FILE: tb/tb_top.sv
// top of the pair energy testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module tb_top;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int ITEM_GOAL   = 1200;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [lje_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic [1:0]                     in_tuser = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [lje_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [1:0]                     out_tuser;
  int                             mismatches;
  int                             pending;
  int                             cycles = 0;
  int                             beats_sent = 0;
  int                             send_idle = 0;
  int                             recv_stall = 0;

  lennard_jones_pair_energy dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser
  );

  lje_energy_checker u_checker (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .mismatches, .pending
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= (recv_stall == 0) ? 1'b1 : ($urandom_range(99) >= recv_stall);
  end

  task automatic send_beat(lje_pkg::kind_t k, logic [31:0] x, logic [31:0] y,
                           logic [31:0] z, logic [3:0] t1, logic [3:0] t2,
                           logic [31:0] rep, logic [31:0] att);
    while (send_idle != 0 && $urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= k;
    in_tdata <= {att, rep, t2, t1, z, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic load_atom(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [3:0] t);
    send_beat(lje_pkg::KIND_ATOM, x, y, z, t, 4'($urandom), $urandom, $urandom);
  endtask

  task automatic load_pair(logic [3:0] t1, logic [3:0] t2, logic [31:0] rep,
                           logic [31:0] att);
    send_beat(lje_pkg::KIND_PARAM, $urandom, $urandom, $urandom, t1, t2, rep, att);
  endtask

  task automatic run_compute();
    send_beat(lje_pkg::KIND_COMPUTE, $urandom, $urandom, $urandom, 4'($urandom),
              4'($urandom), $urandom, $urandom);
  endtask

  function automatic logic [31:0] rand_len();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(32'h0000_4000);
      default: return 32'h0001_0000 + $urandom_range(32'h0000_8000) - 32'h0000_4000;
    endcase
  endfunction

  // atoms of one run cluster around a center, most coordinates within +-4.0 of it
  function automatic logic [31:0] near(logic [31:0] c);
    if ($urandom_range(9) == 0) return $urandom;
    return c + $urandom_range(32'h0008_0000) - 32'h0004_0000;
  endfunction

  initial begin
    logic [31:0] cx, cy, cz, lx, ly, lz;
    int n;
    bit full_done;
    full_done = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed part
    run_compute();
    load_atom(32'h0001_0000, 0, 0, 4'd1);
    run_compute();
    load_pair(4'd1, 4'd2, 32'h0001_0000, 32'h0001_0000);
    load_atom(0, 0, 0, 4'd2);
    load_atom(32'h0001_0000, 0, 0, 4'd1);
    run_compute();
    load_pair(4'd3, 4'd3, 32'h0000_e000, 32'h0001_2000);
    load_atom(32'h0002_0000, 32'hffff_0000, 0, 4'd3);
    load_atom(32'h0002_0000, 32'hffff_0000, 0, 4'd3);
    load_atom(32'h0002_8000, 32'hffff_0000, 32'h0000_4000, 4'd3);
    run_compute();
    load_pair(4'd15, 4'd0, 32'hffff_ffff, 32'h0000_0000);
    send_beat(lje_pkg::KIND_NONE, '1, '1, '1, 4'hf, 4'hf, '1, '1);
    load_atom(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 4'd15);
    load_atom(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 4'd0);
    load_atom(32'h7fff_0000, 32'h8000_0000, 32'h7fff_ffff, 4'd0);
    load_atom(32'h7fff_0001, 32'h8000_0000, 32'h7fff_ffff, 4'd15);
    run_compute();
    load_pair(4'd0, 4'd15, 32'h0000_0001, 32'hffff_ffff);
    load_atom(0, 0, 32'h0000_0100, 4'd0);
    load_atom(0, 0, 0, 4'd15);
    run_compute();

    // random part
    while (beats_sent < ITEM_GOAL) begin
      case ((beats_sent / 150) % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 71; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 71; end
        default: begin send_idle = 13; recv_stall = 13; end
      endcase
      if ($urandom_range(99) < 20) begin
        load_pair(4'($urandom), 4'($urandom), rand_len(), rand_len());
      end else if ($urandom_range(99) < 4) begin
        send_beat(lje_pkg::KIND_NONE, $urandom, $urandom, $urandom, 4'($urandom),
                  4'($urandom), $urandom, $urandom);
      end else begin
        cx = $urandom;
        cy = $urandom;
        cz = $urandom;
        n = $urandom_range(7);
        if (!full_done && beats_sent > 600) begin
          n = lje_pkg::MAX_ATOMS_DEF + 3;
          full_done = 1;
        end
        lx = cx; ly = cy; lz = cz;
        for (int k = 0; k < n; k++) begin
          if ($urandom_range(11) != 0) begin
            lx = near(cx);
            ly = near(cy);
            lz = near(cz);
          end
          load_atom(lx, ly, lz, 4'($urandom_range(4) == 0 ? $urandom : $urandom_range(3)));
        end
        run_compute();
      end
    end
    in_tvalid <= 1'b0;

    // let the checker record the last accepted beat before looking at pending
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
